// ===== design/omni_wheel_odometry_unit_assert.svh =====
// Assertion macros for the omni wheel odometry unit.
`ifndef OMNI_WHEEL_ODOMETRY_UNIT_ASSERT_SVH
`define OMNI_WHEEL_ODOMETRY_UNIT_ASSERT_SVH
// Implication checked every clock outside reset.
`define OWO_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
// Next-cycle implication checked outside reset.
`define OWO_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`endif

// ===== design/owo_pkg.sv =====
// Package for the omni wheel odometry unit: payload types, codes and constants.
`default_nettype none
package owo_pkg;
  typedef struct packed {
    logic signed [31:0] wheel_one_angle;
    logic signed [31:0] wheel_two_angle;
    logic signed [31:0] wheel_three_angle;
    logic signed [31:0] wheel_four_angle;
  } owo_in_t;

  typedef struct packed {
    logic signed [31:0] pose_x;
    logic signed [31:0] pose_y;
    logic        [23:0] heading;
  } owo_out_t;

  typedef enum logic [2:0] {
    ST_IDLE, ST_LANE, ST_MUL, ST_RND, ST_UPD, ST_OUT
  } owo_state_e;

  localparam logic [15:0] LINEAR_GAIN_RESET  = 16'd655;
  localparam logic [15:0] ANGULAR_GAIN_RESET = 16'd49449;
  localparam logic [29:0] SQRT_HALF_Q30      = 30'd759250125;
  localparam logic        REG_LINEAR_GAIN    = 1'b0;
  localparam logic        REG_ANGULAR_GAIN   = 1'b1;

  // Round a signed value right by sh bits, halves away from zero.
  function automatic logic signed [63:0] round_shift(input logic signed [63:0] v,
                                                      input int unsigned sh);
    logic [63:0] m;
    m = v[63] ? (64'd0 - v) : v;
    m = (m + (64'd1 << (sh - 1))) >> sh;
    return v[63] ? $signed(64'd0 - m) : $signed(m);
  endfunction
endpackage
`default_nettype wire

// ===== design/omni_wheel_odometry_unit.sv =====
// The result is valid after the lane, multiply, round and update states; one request at a time.
// A new request is taken only in idle, after the output is accepted; lanes run in parallel,
// the merge steps (sum, multiply, round, update) run one after another.
// Reset clears pose, stored angles, primed flag and gains to defaults.
// The first request only loads angles and reports the reset pose.
`default_nettype none
module omni_wheel_odometry_unit #(
  parameter int HEADING_BITS = 24
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_ready_o,
  input  wire owo_pkg::owo_in_t  in_data_i,
  output logic                   out_valid_o,
  input  wire logic              out_ready_i,
  output owo_pkg::owo_out_t      out_data_o,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [2:0]        paddr,
  input  wire logic [31:0]       pwdata,
  output logic [31:0]            prdata,
  output logic                   pready
);
  import owo_pkg::*;
`include "omni_wheel_odometry_unit_assert.svh"

  owo_state_e state_q, state_d;
  logic [15:0] lin_q, ang_q;
  logic primed_q;
  logic signed [32:0] d0, d1, d2, d3;
  logic load;
  owo_out_t pose;

  // Configuration: word addressed registers, selected by the word index.
  assign pready = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lin_q <= LINEAR_GAIN_RESET;
      ang_q <= ANGULAR_GAIN_RESET;
    end else if (psel && penable && pwrite && pready) begin
      case (paddr[2])
        REG_LINEAR_GAIN:  lin_q <= pwdata[15:0];
        REG_ANGULAR_GAIN: ang_q <= pwdata[15:0];
        default: ;
      endcase
    end
  end
  always_comb begin
    case (paddr[2])
      REG_LINEAR_GAIN:  prdata = {16'd0, lin_q};
      REG_ANGULAR_GAIN: prdata = {16'd0, ang_q};
      default:          prdata = '0;
    endcase
  end

  // Sequencer: accept, lanes, multiply, round, update, present.
  assign load = in_valid_i && in_ready_o;
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: if (in_valid_i) state_d = ST_LANE;
      ST_LANE: state_d = ST_MUL;
      ST_MUL:  state_d = ST_RND;
      ST_RND:  state_d = ST_UPD;
      ST_UPD:  state_d = ST_OUT;
      ST_OUT:  if (out_ready_i) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end
  always_comb begin
    in_ready_o  = (state_q == ST_IDLE);
    out_valid_o = (state_q == ST_OUT);
  end
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      primed_q <= 1'b0;
    end else begin
      state_q <= state_d;
      // Advance primed once the first request has passed the update step.
      if (state_q == ST_UPD) primed_q <= 1'b1;
    end
  end

  owo_lane u_lane0 (.clk_i, .rst_ni, .load_i(load), .angle_i(in_data_i.wheel_one_angle),
                    .delta_o(d0));
  owo_lane u_lane1 (.clk_i, .rst_ni, .load_i(load), .angle_i(in_data_i.wheel_two_angle),
                    .delta_o(d1));
  owo_lane u_lane2 (.clk_i, .rst_ni, .load_i(load), .angle_i(in_data_i.wheel_three_angle),
                    .delta_o(d2));
  owo_lane u_lane3 (.clk_i, .rst_ni, .load_i(load), .angle_i(in_data_i.wheel_four_angle),
                    .delta_o(d3));

  owo_merge #(.HEADING_BITS(HEADING_BITS)) u_merge (
    .clk_i, .rst_ni, .state_i(state_q), .primed_i(primed_q),
    .linear_gain_i(lin_q), .angular_gain_i(ang_q),
    .d0_i(d0), .d1_i(d1), .d2_i(d2), .d3_i(d3), .pose_o(pose));

  assign out_data_o = pose;

  `OWO_ASSERT_IMP(a_excl, clk_i, rst_ni, out_valid_o, !in_ready_o, "accept during output")
  `OWO_ASSERT_NXT(a_hold, clk_i, rst_ni, out_valid_o && !out_ready_i, $stable(out_data_o),
                  "pose changed while stalled")
  `OWO_ASSERT_NXT(a_seq, clk_i, rst_ni, load, state_q == ST_LANE, "accept did not start lanes")
endmodule
`default_nettype wire

// ===== design/owo_lane.sv =====
// One wheel lane: delta from the stored angle, held last angle.
`default_nettype none
module owo_lane (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               load_i,
  input  wire logic signed [31:0] angle_i,
  output logic signed [32:0]      delta_o
);
  logic signed [31:0] last_q;
  logic signed [32:0] delta_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_q  <= '0;
      delta_q <= '0;
    end else if (load_i) begin
      delta_q <= 33'(angle_i) - 33'(last_q);
      last_q  <= angle_i;
    end
  end
  assign delta_o = delta_q;
endmodule
`default_nettype wire

// ===== design/owo_merge.sv =====
// Merge stage: combine lane deltas, scale, round and update the pose.
`default_nettype none
module owo_merge #(
  parameter int HEADING_BITS = 24
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire owo_pkg::owo_state_e state_i,
  input  wire logic               primed_i,
  input  wire logic [15:0]        linear_gain_i,
  input  wire logic [15:0]        angular_gain_i,
  input  wire logic signed [32:0] d0_i,
  input  wire logic signed [32:0] d1_i,
  input  wire logic signed [32:0] d2_i,
  input  wire logic signed [32:0] d3_i,
  output owo_pkg::owo_out_t       pose_o
);
  import owo_pkg::*;
  logic signed [34:0] sq_q, sp_q, sa_q;
  logic signed [63:0] px_q, py_q, ph_q;
  logic signed [63:0] rx_q, ry_q, rh_q;
  logic signed [24:0] k_q;
  logic signed [31:0] x_q, y_q;
  logic [HEADING_BITS-1:0] h_q;
  logic signed [63:0] k_w, sx, sy;
  logic [45:0] kraw;

  assign kraw = 46'(linear_gain_i) * 46'(SQRT_HALF_Q30);
  assign k_w  = round_shift(64'(kraw), 22);
  assign sx   = 64'(x_q) + rx_q;
  assign sy   = 64'(y_q) + ry_q;

  always_ff @(posedge clk_i) begin
    if (state_i == ST_LANE) begin
      sq_q <= 35'(d0_i) + 35'(d1_i) - 35'(d2_i) - 35'(d3_i);
      sp_q <= 35'(d0_i) - 35'(d1_i) - 35'(d2_i) + 35'(d3_i);
      sa_q <= 35'(d0_i) + 35'(d1_i) + 35'(d2_i) + 35'(d3_i);
      k_q  <= 25'(k_w);
    end
    if (state_i == ST_MUL) begin
      px_q <= 64'(sq_q) * 64'(k_q);
      py_q <= 64'(sp_q) * 64'(k_q);
      ph_q <= 64'(sa_q) * $signed({48'd0, angular_gain_i});
    end
    if (state_i == ST_RND) begin
      rx_q <= round_shift(px_q, 24);
      ry_q <= round_shift(py_q, 24);
      rh_q <= round_shift(ph_q, 40 - HEADING_BITS);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      x_q <= '0;
      y_q <= '0;
      h_q <= '0;
    end else if (state_i == ST_UPD && primed_i) begin
      x_q <= (sx > 64'sd2147483647) ? 32'sh7fffffff :
             (sx < -64'sd2147483648) ? 32'sh80000000 : sx[31:0];
      y_q <= (sy > 64'sd2147483647) ? 32'sh7fffffff :
             (sy < -64'sd2147483648) ? 32'sh80000000 : sy[31:0];
      h_q <= h_q - HEADING_BITS'(rh_q);
    end
  end

  always_comb begin
    logic [31:0] hw;
    hw = 32'(h_q);
    pose_o.pose_x  = x_q;
    pose_o.pose_y  = y_q;
    pose_o.heading = hw[23:0];
  end
endmodule
`default_nettype wire
